/* rtl/fcrm_pkg.sv */
`timescale 1ns / 1ps

package fcrm_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int MIX_W      = 16;
    localparam int IRL_W      = 11;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int KIND_W     = 2;

    // shared multiplier and wet-sum slicing
    localparam int MUL_W      = 17;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int CHUNK_LOG2 = 4;
    localparam int CHUNK_W    = 1 << CHUNK_LOG2;

    // mix arithmetic
    localparam logic [MIX_W-1:0] MIX_ONE   = 16'd32768;
    localparam logic [MIX_W-1:0] MIX_RESET = 16'd16384;
    localparam int DRY_SHIFT   = 15;
    localparam int ROUND_SHIFT = 30;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COEF   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIX       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IR_LENGTH = 2'd2;

    // what the product register carries
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_MAC  = 2'd1;
    localparam logic [1:0] OP_DRY  = 2'd2;
    localparam logic [1:0] OP_WET  = 2'd3;

    typedef struct packed {
        logic load_sample;
        logic load_bypass;
        logic coef_wr;
        logic clear;
        logic mac_issue;
        logic mix_issue;
    } fcrm_cmd_t;

    typedef struct packed {
        logic active;
        logic tap_last;
        logic mix_last;
        logic pipe_busy;
    } fcrm_sts_t;

endpackage

/* rtl/fcrm_dp.sv */
`timescale 1ns / 1ps

module fcrm_dp #(
    parameter int MAX_TAPS = 1024,
    localparam int TAP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fcrm_pkg::fcrm_cmd_t                   cmd,
    output fcrm_pkg::fcrm_sts_t                   sts,
    input  logic                                  bypass,
    input  logic [fcrm_pkg::MIX_W-1:0]            mix,
    input  logic [fcrm_pkg::IRL_W-1:0]            ir_length,
    input  logic signed [fcrm_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic [TAP_W-1:0]                      tap_index,
    input  logic signed [fcrm_pkg::COEF_W-1:0]    coef_value,
    output logic signed [fcrm_pkg::SAMPLE_W-1:0]  result
);

    localparam int LEN_W   = $clog2(MAX_TAPS + 1);
    localparam int LCMP_W  = (LEN_W > fcrm_pkg::IRL_W) ? LEN_W : fcrm_pkg::IRL_W;
    localparam int ACC_W   = fcrm_pkg::SAMPLE_W + fcrm_pkg::COEF_W + LEN_W;
    localparam int NCHUNK  = (ACC_W + fcrm_pkg::CHUNK_W - 1) / fcrm_pkg::CHUNK_W;
    localparam int ACCX_W  = NCHUNK * fcrm_pkg::CHUNK_W;
    localparam int T_W     = ACCX_W + fcrm_pkg::PROD_W - fcrm_pkg::CHUNK_W;
    localparam int CIDX_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int MSTEP_W = $clog2(NCHUNK + 1);

    localparam logic signed [T_W-1:0] RND   = T_W'(1) <<< (fcrm_pkg::ROUND_SHIFT - 1);
    localparam logic signed [T_W-1:0] S_MAX = T_W'((1 <<< (fcrm_pkg::SAMPLE_W - 1)) - 1);
    localparam logic signed [T_W-1:0] S_MIN = ~S_MAX;

    // storage
    logic signed [fcrm_pkg::SAMPLE_W-1:0] hist_mem [MAX_TAPS];
    logic signed [fcrm_pkg::COEF_W-1:0]   coef_mem [MAX_TAPS];

    logic signed [fcrm_pkg::SAMPLE_W-1:0] hist_q_reg;
    logic signed [fcrm_pkg::COEF_W-1:0]   coef_q_reg;

    // control registers
    logic [TAP_W-1:0]   wp_reg,    wp_next;
    logic [LEN_W-1:0]   fill_reg,  fill_next;
    logic [TAP_W-1:0]   rp_reg,    rp_next;
    logic [TAP_W-1:0]   j_reg,     j_next;
    logic [MSTEP_W-1:0] mstep_reg, mstep_next;
    logic               v1_reg;
    logic [1:0]         op_reg,    op_next;

    // payload registers
    logic signed [fcrm_pkg::SAMPLE_W-1:0] dry_reg;
    logic                                 passthru_reg;
    logic                                 hv_reg;
    logic signed [fcrm_pkg::PROD_W-1:0]   prod_reg;
    logic [CIDX_W-1:0]                    cidx_reg;
    logic signed [ACC_W-1:0]              acc_reg;
    logic signed [T_W-1:0]                t_reg;

    logic [LCMP_W-1:0]                irl_ext;
    logic [LEN_W-1:0]                 len;
    logic [fcrm_pkg::MIX_W-1:0]       mix_c;
    logic [TAP_W-1:0]                 pos_eff;
    logic [LEN_W-1:0]                 pos_inc;
    logic                             tap_ok;
    logic signed [fcrm_pkg::MUL_W-1:0] op_a;
    logic signed [fcrm_pkg::MUL_W-1:0] op_b;
    logic signed [fcrm_pkg::MUL_W-1:0] one_minus;
    logic signed [fcrm_pkg::MUL_W-1:0] chunk;
    logic signed [ACCX_W-1:0]         acc_ext;
    logic signed [T_W-1:0]            prod_t;
    logic [CIDX_W+fcrm_pkg::CHUNK_LOG2-1:0] wet_sh;
    logic signed [T_W-1:0]            t_rnd;
    logic signed [T_W-1:0]            y_full;
    logic signed [fcrm_pkg::SAMPLE_W-1:0] y_sat;

    assign irl_ext = LCMP_W'(ir_length);
    assign len     = (irl_ext > LCMP_W'(MAX_TAPS)) ? LEN_W'(MAX_TAPS) : LEN_W'(irl_ext);
    assign mix_c   = (mix > fcrm_pkg::MIX_ONE) ? fcrm_pkg::MIX_ONE : mix;
    assign tap_ok  = (LEN_W'(tap_index) < LEN_W'(MAX_TAPS));

    // a shrunken ring restarts at zero
    assign pos_eff = (LEN_W'(wp_reg) >= len) ? '0 : wp_reg;
    assign pos_inc = LEN_W'(pos_eff) + LEN_W'(1);

    assign sts.active    = !bypass && (len != '0);
    assign sts.tap_last  = (LEN_W'(j_reg) == len - LEN_W'(1));
    assign sts.mix_last  = (mstep_reg == MSTEP_W'(NCHUNK));
    assign sts.pipe_busy = v1_reg || (op_reg != fcrm_pkg::OP_NONE);

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            hist_mem[pos_eff] <= sample_in;
        end
        if (cmd.mac_issue)
        begin
            hist_q_reg <= hist_mem[rp_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.coef_wr && tap_ok)
        begin
            coef_mem[tap_index] <= coef_value;
        end
        if (cmd.mac_issue)
        begin
            coef_q_reg <= coef_mem[j_reg];
        end
    end

    // pointers and counters
    always_comb
    begin
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        rp_next    = rp_reg;
        j_next     = j_reg;
        mstep_next = mstep_reg;
        if (cmd.clear)
        begin
            wp_next   = '0;
            fill_next = '0;
        end
        if (cmd.load_sample)
        begin
            wp_next = (pos_inc == len) ? '0 : TAP_W'(pos_inc);
            // entries at or above the fill mark were never written since clear
            if (pos_inc > fill_reg)
            begin
                fill_next = pos_inc;
            end
            rp_next    = pos_eff;
            j_next     = '0;
            mstep_next = '0;
        end
        if (cmd.mac_issue)
        begin
            rp_next = (rp_reg == '0) ? TAP_W'(len - LEN_W'(1)) : rp_reg - TAP_W'(1);
            j_next  = j_reg + TAP_W'(1);
        end
        if (cmd.mix_issue)
        begin
            mstep_next = mstep_reg + MSTEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            fill_reg  <= '0;
            rp_reg    <= '0;
            j_reg     <= '0;
            mstep_reg <= '0;
            v1_reg    <= 1'b0;
            op_reg    <= fcrm_pkg::OP_NONE;
        end
        else
        begin
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            rp_reg    <= rp_next;
            j_reg     <= j_next;
            mstep_reg <= mstep_next;
            v1_reg    <= cmd.mac_issue;
            op_reg    <= op_next;
        end
    end

    // wet sum taken apart in 16-bit slices, top slice signed
    assign acc_ext   = ACCX_W'(acc_reg);
    assign one_minus = $signed({1'b0, fcrm_pkg::MIX_ONE - mix_c});

    always_comb
    begin
        chunk = '0;
        for (int k = 0; k < NCHUNK; k++)
        begin
            if (MSTEP_W'(k + 1) == mstep_reg)
            begin
                if (k == NCHUNK - 1)
                begin
                    chunk = $signed({acc_ext[k*fcrm_pkg::CHUNK_W + fcrm_pkg::CHUNK_W - 1],
                                     acc_ext[k*fcrm_pkg::CHUNK_W +: fcrm_pkg::CHUNK_W]});
                end
                else
                begin
                    chunk = $signed({1'b0, acc_ext[k*fcrm_pkg::CHUNK_W +: fcrm_pkg::CHUNK_W]});
                end
            end
        end
    end

    // operand select for the one shared multiplier
    always_comb
    begin
        op_a    = '0;
        op_b    = '0;
        op_next = fcrm_pkg::OP_NONE;
        if (cmd.mix_issue)
        begin
            if (mstep_reg == '0)
            begin
                op_a    = fcrm_pkg::MUL_W'(dry_reg);
                op_b    = one_minus;
                op_next = fcrm_pkg::OP_DRY;
            end
            else
            begin
                op_a    = chunk;
                op_b    = $signed({1'b0, mix_c});
                op_next = fcrm_pkg::OP_WET;
            end
        end
        else if (v1_reg)
        begin
            op_a    = hv_reg ? fcrm_pkg::MUL_W'(hist_q_reg) : '0;
            op_b    = fcrm_pkg::MUL_W'(coef_q_reg);
            op_next = fcrm_pkg::OP_MAC;
        end
    end

    assign prod_t = T_W'(prod_reg);
    assign wet_sh = {cidx_reg, {fcrm_pkg::CHUNK_LOG2{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample || cmd.load_bypass)
        begin
            dry_reg      <= sample_in;
            passthru_reg <= cmd.load_bypass;
        end
        if (cmd.mac_issue)
        begin
            hv_reg <= (LEN_W'(rp_reg) < fill_reg);
        end
        prod_reg <= op_a * op_b;
        if (cmd.mix_issue)
        begin
            cidx_reg <= CIDX_W'(mstep_reg - MSTEP_W'(1));
        end
        if (cmd.load_sample)
        begin
            acc_reg <= '0;
            t_reg   <= '0;
        end
        else
        begin
            case (op_reg)
                fcrm_pkg::OP_MAC: acc_reg <= acc_reg + ACC_W'(prod_reg);
                fcrm_pkg::OP_DRY: t_reg   <= t_reg + (prod_t <<< fcrm_pkg::DRY_SHIFT);
                fcrm_pkg::OP_WET: t_reg   <= t_reg + (prod_t <<< wet_sh);
                default:          ;
            endcase
        end
    end

    // round half up, then saturate
    assign t_rnd  = t_reg + RND;
    assign y_full = t_rnd >>> fcrm_pkg::ROUND_SHIFT;
    assign y_sat  = (y_full > S_MAX) ? fcrm_pkg::SAMPLE_W'(S_MAX) :
                    (y_full < S_MIN) ? fcrm_pkg::SAMPLE_W'(S_MIN) :
                    fcrm_pkg::SAMPLE_W'(y_full);
    assign result = passthru_reg ? dry_reg : y_sat;

    a_taps_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mac_issue |-> (LEN_W'(rp_reg) < len) && (LEN_W'(j_reg) < len))
        else $error("tap read outside the ring");

    a_mac_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mix_issue |-> !v1_reg)
        else $error("mix step started with taps still in flight");

    a_pos_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_sample |=> (LEN_W'(wp_reg) < len))
        else $error("write position left the ring");

endmodule

/* rtl/fcrm_ctrl.sv */
`timescale 1ns / 1ps

module fcrm_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [fcrm_pkg::KIND_W-1:0]  kind,
    input  logic                         out_free,
    output logic                         out_load,
    output fcrm_pkg::fcrm_cmd_t          cmd,
    input  fcrm_pkg::fcrm_sts_t          sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_MIX   = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (kind)
                        fcrm_pkg::KIND_SAMPLE:
                        begin
                            if (sts.active)
                            begin
                                cmd.load_sample = 1'b1;
                                state_next      = S_MAC;
                            end
                            else
                            begin
                                cmd.load_bypass = 1'b1;
                                state_next      = S_OUT;
                            end
                        end
                        fcrm_pkg::KIND_COEF:  cmd.coef_wr = 1'b1;
                        fcrm_pkg::KIND_CLEAR: cmd.clear   = 1'b1;
                        default:              ;
                    endcase
                end
            end
            S_MAC:
            begin
                cmd.mac_issue = 1'b1;
                if (sts.tap_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = S_MIX;
                end
            end
            S_MIX:
            begin
                cmd.mix_issue = 1'b1;
                if (sts.mix_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> in_ready)
        else $error("not ready for a request after handing over a result");

endmodule

/* rtl/fir_convolution_reverb_mix.sv */
`timescale 1ns / 1ps
// channel   dir  handshake              payload
// in        in   in_valid / in_ready    kind, sample_in, tap_index, coef_value
// out       out  out_valid / out_ready  sample_out
// cfg       in   cfg_wr_en              cfg_index, cfg_data
//
// audio request: one multiply-accumulate per tap through the single read port of
//   each memory, then one multiply for the dry path and one per 16-bit slice of
//   the wet sum; a new request is taken once the result is handed over
// bypass or empty response: dry sample passed on; coef and clear: stay in idle
// reset: no clearing pass, history at or above the fill mark reads as zero
// a finished result waits in the output register; a new request is taken
// meanwhile, and its own result waits until that register is free

module fir_convolution_reverb_mix #(
    parameter int MAX_TAPS = 1024,
    localparam int TAP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [fcrm_pkg::KIND_W-1:0]           kind,
    input  logic signed [fcrm_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic [TAP_W-1:0]                      tap_index,
    input  logic signed [fcrm_pkg::COEF_W-1:0]    coef_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [fcrm_pkg::SAMPLE_W-1:0]  sample_out,
    input  logic                                  cfg_wr_en,
    input  logic [fcrm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fcrm_pkg::CFG_W-1:0]            cfg_data
);

    logic                            bypass_reg;
    logic [fcrm_pkg::MIX_W-1:0]      mix_reg;
    logic [fcrm_pkg::IRL_W-1:0]      irl_reg;
    logic                            out_valid_reg;
    logic signed [fcrm_pkg::SAMPLE_W-1:0] sample_out_reg;

    fcrm_pkg::fcrm_cmd_t             cmd;
    fcrm_pkg::fcrm_sts_t             sts;
    logic                            out_free;
    logic                            out_load;
    logic signed [fcrm_pkg::SAMPLE_W-1:0] result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg <= 1'b0;
            mix_reg    <= fcrm_pkg::MIX_RESET;
            irl_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                fcrm_pkg::REG_BYPASS:    bypass_reg <= cfg_data[0];
                fcrm_pkg::REG_MIX:       mix_reg    <= cfg_data[fcrm_pkg::MIX_W-1:0];
                fcrm_pkg::REG_IR_LENGTH: irl_reg    <= cfg_data[fcrm_pkg::IRL_W-1:0];
                default:                 ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    fcrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .out_free (out_free),
        .out_load (out_load),
        .cmd      (cmd),
        .sts      (sts)
    );

    fcrm_dp #(
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .bypass     (bypass_reg),
        .mix        (mix_reg),
        .ir_length  (irl_reg),
        .sample_in  (sample_in),
        .tap_index  (tap_index),
        .coef_value (coef_value),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sample_out_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("result written over one not yet taken");

endmodule

/* verif/reverb_mix_checker.sv */
`timescale 1ns / 1ps

module reverb_mix_checker #(
    parameter int MAX_TAPS = 1024,
    parameter int TAP_W    = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic [fcrm_pkg::KIND_W-1:0]           kind,
    input  logic signed [fcrm_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic [TAP_W-1:0]                      tap_index,
    input  logic signed [fcrm_pkg::COEF_W-1:0]    coef_value,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic signed [fcrm_pkg::SAMPLE_W-1:0]  sample_out,
    input  logic                                  cfg_wr_en,
    input  logic [fcrm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fcrm_pkg::CFG_W-1:0]            cfg_data,
    output int                                    mismatch_count,
    output int                                    outstanding
);
    import fcrm_pkg::*;

    logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
    logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
    logic [TAP_W-1:0]           ring_pos;
    logic                       bypass_reg;
    logic [MIX_W-1:0]           mix_reg;
    logic [IRL_W-1:0]           len_reg;
    logic signed [SAMPLE_W-1:0] expected_samples [$];
    logic signed [SAMPLE_W-1:0] want;

    // convolves the new sample against the loaded response and blends it with the dry path
    function automatic logic signed [SAMPLE_W-1:0] mix_sample(
        input logic signed [SAMPLE_W-1:0] dry
    );
        int     taps;
        int     pos;
        longint share;
        longint wet_sum;
        longint blend;
        longint rounded;
        longint top;
        taps  = (len_reg > MAX_TAPS) ? MAX_TAPS : int'(len_reg);
        share = (mix_reg > MIX_ONE) ? longint'(MIX_ONE) : longint'(mix_reg);
        if (bypass_reg || taps == 0)
            return dry;
        // ring shrank under the write position
        if (int'(ring_pos) >= taps)
            ring_pos = '0;
        pos = int'(ring_pos);
        hist_mem[pos] = dry;
        wet_sum = 0;
        for (int j = 0; j < taps; j++)
            wet_sum += longint'(hist_mem[(pos + taps - j) % taps]) * longint'(coef_mem[j]);
        blend = longint'(dry) * (longint'(MIX_ONE) - share) * (longint'(1) << DRY_SHIFT)
                + wet_sum * share;
        rounded = (blend + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        ring_pos = TAP_W'((pos + 1) % taps);
        top = (longint'(1) << (SAMPLE_W - 1)) - 1;
        if (rounded > top)
            rounded = top;
        if (rounded < -top - 1)
            rounded = -top - 1;
        return SAMPLE_W'(rounded);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                hist_mem[i] = '0;
                coef_mem[i] = '0;
            end
            ring_pos       = '0;
            bypass_reg     = 1'b0;
            mix_reg        = MIX_RESET;
            len_reg        = '0;
            expected_samples.delete();
            mismatch_count = 0;
            outstanding    = 0;
        end
        else
        begin
            // results first: a result never belongs to a request taken at the same edge
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: sample_out expected none, got %0d", $time, sample_out);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample_out !== want)
                    begin
                        $display("%0t: sample_out expected %0d, got %0d",
                                 $time, want, sample_out);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_BYPASS:    bypass_reg = cfg_data[0];
                    REG_MIX:       mix_reg    = cfg_data[MIX_W-1:0];
                    REG_IR_LENGTH: len_reg    = cfg_data[IRL_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                case (kind)
                    KIND_SAMPLE: expected_samples.push_back(mix_sample(sample_in));
                    KIND_COEF:   coef_mem[tap_index] = coef_value;
                    KIND_CLEAR:
                    begin
                        for (int i = 0; i < MAX_TAPS; i++)
                            hist_mem[i] = '0;
                        ring_pos = '0;
                    end
                    default: ;
                endcase
            end
            outstanding = expected_samples.size();
        end
    end

endmodule

/* verif/fir_convolution_reverb_mix_tb.sv */
`timescale 1ns / 1ps

module fir_convolution_reverb_mix_tb;
    import fcrm_pkg::*;

    localparam int MAX_TAPS    = 1024;
    localparam int TAP_W       = $clog2(MAX_TAPS);
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_MAX    = 17;
    localparam int PHASE_ITEMS = 48;
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [KIND_W-1:0]          kind;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [TAP_W-1:0]           tap_index;
    logic signed [COEF_W-1:0]   coef_value;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       cfg_wr_en;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;

    int fail_count;
    int pending;
    bit tap_written [MAX_TAPS];
    int ir_taps;
    bit no_idle;
    bit hold_output;

    fir_convolution_reverb_mix #(
        .MAX_TAPS (MAX_TAPS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .sample_in  (sample_in),
        .tap_index  (tap_index),
        .coef_value (coef_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    reverb_mix_checker #(
        .MAX_TAPS (MAX_TAPS),
        .TAP_W    (TAP_W)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .sample_in      (sample_in),
        .tap_index      (tap_index),
        .coef_value     (coef_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_out     (sample_out),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (fail_count),
        .outstanding    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] random_coef();
        // mostly modest taps so that not every wet sum sits on a rail
        if ($urandom_range(0, 3) == 0)
            return COEF_W'($urandom);
        return COEF_W'(int'($urandom_range(0, 4095)) - 2048);
    endfunction

    task automatic send_request(
        input logic [KIND_W-1:0]          k,
        input logic signed [SAMPLE_W-1:0] s,
        input logic [TAP_W-1:0]           t,
        input logic signed [COEF_W-1:0]   c
    );
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        sample_in  <= s;
        tap_index  <= t;
        coef_value <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        send_request(KIND_SAMPLE, s, TAP_W'($urandom), COEF_W'($urandom));
    endtask

    task automatic write_tap(input logic [TAP_W-1:0] t, input logic signed [COEF_W-1:0] c);
        send_request(KIND_COEF, SAMPLE_W'($urandom), t, c);
        tap_written[t] = 1'b1;
    endtask

    // drain every result, then give a trailing coefficient or clear request time to finish
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (ir_taps + 16) @(posedge clk);
    endtask

    task automatic load_config(
        input logic             byp,
        input logic [MIX_W-1:0] mixv,
        input logic [IRL_W-1:0] lenv
    );
        logic [CFG_W-1:0] junk;
        // every tap that the new length reads must hold a written value
        for (int i = 0; i < lenv && i < MAX_TAPS; i++)
            if (!tap_written[i])
                write_tap(TAP_W'(i), random_coef());
        settle();
        junk = CFG_W'($urandom);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BYPASS;
        cfg_data  <= {junk[CFG_W-1:1], byp};
        @(posedge clk);
        cfg_index <= REG_MIX;
        cfg_data  <= mixv;
        @(posedge clk);
        cfg_index <= REG_IR_LENGTH;
        cfg_data  <= {junk[CFG_W-1:IRL_W], lenv};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        ir_taps = (lenv > MAX_TAPS) ? MAX_TAPS : int'(lenv);
    endtask

    task automatic run_phase(input int count);
        int done;
        int pick;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 84)
                send_sample(random_sample());
            else if (pick < 93)
                write_tap(TAP_W'($urandom_range(0, MAX_TAPS - 1)), random_coef());
            else if (pick < 96)
                send_request(KIND_CLEAR, SAMPLE_W'($urandom), TAP_W'($urandom),
                             COEF_W'($urandom));
            else
                send_request(KIND_RESERVED, SAMPLE_W'($urandom), TAP_W'($urandom),
                             COEF_W'($urandom));
            // ignored requests do not count
            if (pick < 96)
                done++;
        end
    endtask

    initial
    begin
        int stall;
        bit held;
        out_ready = 1'b0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_output && !held)
            begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("fir_convolution_reverb_mix_tb: FAIL");
        $finish;
    end

    initial
    begin
        logic [MIX_W-1:0] mix_pick;
        in_valid    = 1'b0;
        kind        = KIND_SAMPLE;
        sample_in   = '0;
        tap_index   = '0;
        coef_value  = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_BYPASS;
        cfg_data    = '0;
        ir_taps     = 0;
        no_idle     = 1'b0;
        hold_output = 1'b0;
        rst_n       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // no response loaded yet: samples pass straight through
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_request(KIND_RESERVED, SAMPLE_W'($urandom), TAP_W'($urandom), COEF_W'($urandom));
        send_request(KIND_CLEAR, SAMPLE_W'($urandom), TAP_W'($urandom), COEF_W'($urandom));
        write_tap(TAP_W'(0), 16'sh8000);
        write_tap(TAP_W'(1), 16'sh7fff);
        write_tap(TAP_W'(2), 16'sh8000);
        write_tap(TAP_W'(3), 16'sh8000);
        write_tap(TAP_W'(MAX_TAPS - 1), 16'sh0001);

        // fully wet, largest products push the sum onto both rails
        load_config(1'b0, MIX_ONE, 11'd4);
        repeat (3) send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_request(KIND_CLEAR, SAMPLE_W'($urandom), TAP_W'($urandom), COEF_W'($urandom));
        send_sample(16'sd100);
        send_sample(-16'sd100);
        send_sample(16'sd7);

        // ring shrinks below the write position, mix above one is clamped
        load_config(1'b0, 16'hffff, 11'd2);
        send_sample(16'sh4000);
        load_config(1'b0, 16'h0000, 11'd3);
        send_sample(16'sh8001);
        load_config(1'b1, 16'h0000, 11'd4);
        send_sample(-16'sd1);
        send_sample(16'sh7fff);

        for (int p = 0; p < 10; p++)
        begin
            case ($urandom_range(0, 4))
                0:       mix_pick = '0;
                1:       mix_pick = MIX_ONE;
                2:       mix_pick = '1;
                default: mix_pick = MIX_W'($urandom_range(0, 32768));
            endcase
            no_idle     = (p % 3 == 1);
            hold_output = (p >= 4);
            load_config(p == 2, mix_pick,
                        (p == 0) ? 11'd1 : (p == 1) ? 11'd0 : IRL_W'($urandom_range(2, 48)));
            run_phase(PHASE_ITEMS);
        end

        // a longer response than the phases above use
        no_idle = 1'b0;
        load_config(1'b0, MIX_W'($urandom_range(0, 32768)), 11'd64);
        run_phase(8);

        settle();
        if (fail_count == 0 && pending == 0)
            $display("fir_convolution_reverb_mix_tb: PASS");
        else
            $display("fir_convolution_reverb_mix_tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/fcrm_pkg.sv
rtl/fcrm_dp.sv
rtl/fcrm_ctrl.sv
rtl/fir_convolution_reverb_mix.sv
verif/reverb_mix_checker.sv
verif/fir_convolution_reverb_mix_tb.sv
